// ----- hdl/assert_macros.svh -----
// assertion macros used by the job queue rtl file of the scale note transformer
// no dependencies; ASSERT_OFF compiles the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define MSNT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("msnt assertion failed");
`define MSNT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("msnt forbidden condition");
`else
`define MSNT_ASSERT(label, clk, rst_n, prop)
`define MSNT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- hdl/msnt_pkg.sv -----
// types, constants and helper functions of the scale note transformer
// used by every module of the block; no dependencies
`default_nettype none
package msnt_pkg;

	localparam int MaxIntervals   = 12;
	localparam int ArpMaxNotes    = 4;
	localparam int ArpStepSamples = 100;
	localparam int TableEntries   = 12;
	localparam int MaxResults     = (ArpMaxNotes > 3) ? ArpMaxNotes : 3;
	localparam int CntW           = $clog2(MaxResults + 1);
	localparam int IdxW           = (MaxResults > 1) ? $clog2(MaxResults) : 1;
	localparam int FifoDepth      = 8;
	localparam int FifoAw         = $clog2(FifoDepth);
	localparam int PaddrW         = 5;

	localparam logic [1:0] RegMode          = 2'd0;
	localparam logic [1:0] RegRootPitch     = 2'd1;
	localparam logic [1:0] RegIntervalCount = 2'd2;
	localparam logic [1:0] RegIntervalTable = 2'd3;

	localparam logic [3:0] NoteOnNibble = 4'h9;

	typedef enum logic [1:0] {
		ModePass,
		ModeConstrain,
		ModeHarmonize,
		ModeArpeggiate
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  root_pitch;
		logic [3:0]  interval_count;
		logic [47:0] interval_table;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  status_byte;
		logic [6:0]  data_one;
		logic [6:0]  data_two;
		logic [15:0] sample_pos;
	} in_t;

	typedef struct packed {
		logic [7:0]  out_status;
		logic [6:0]  out_data_one;
		logic [6:0]  out_data_two;
		logic [16:0] out_sample_pos;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [7:0]                  status;
		logic [6:0]                  data_two;
		logic [15:0]                 sample_pos;
		logic                        arp;
		logic [CntW-1:0]             count;
		logic [MaxResults-1:0][6:0]  notes;
	} job_t;

	typedef struct packed {
		logic [3:0] gap;
		logic [3:0] deg;
	} node_t;

	// (root + interval) mod 12, sum stays below 36
	function automatic logic [3:0] deg_of(input logic [3:0] root, input logic [3:0] iv);
		logic [4:0] s;
		begin
			s = 5'(root) + 5'(iv);
			if (s >= 5'd24)
				s = s - 5'd24;
			else if (s >= 5'd12)
				s = s - 5'd12;
			return s[3:0];
		end
	endfunction

	// floor(n / 12) by reciprocal, exact for n below 192
	function automatic logic [3:0] div12(input logic [7:0] n);
		logic [15:0] p;
		begin
			p = 16'(n) * 16'd171;
			return p[14:11];
		end
	endfunction

	function automatic logic [7:0] times12(input logic [3:0] oct);
		return 8'({oct, 3'b000}) + 8'({oct, 2'b00});
	endfunction

	function automatic logic [6:0] sat7(input logic [7:0] n);
		return n[7] ? 7'h7f : n[6:0];
	endfunction

	// first one wins on equal distance
	function automatic node_t pick(input node_t a, input node_t b);
		return (b.gap < a.gap) ? b : a;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/msnt_front.sv -----
// front end: takes words, finds snapped notes over three stages, builds jobs
// depends on msnt_pkg
`default_nettype none
module msnt_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire msnt_pkg::in_t  item,
	input  wire msnt_pkg::cfg_t cfg,
	input  wire logic           pop,
	output logic                busy,
	output logic                push,
	output msnt_pkg::job_t      push_job
);

	localparam int FifoAwP1 = msnt_pkg::FifoAw + 1;
	localparam int CntW = msnt_pkg::CntW;

	logic                 vld_s1, vld_s2, vld_s3;
	msnt_pkg::in_t        item_s1, item_s2, item_s3;
	logic                 note_on_s2, note_on_s3;
	logic [2:0][7:0]      cand_s2, cand_s3;
	logic [2:0][3:0]      oct_s2, oct_s3;
	logic [2:0][3:0]      pc_s2;
	msnt_pkg::node_t [2:0][2:0] grp_s3;
	logic [FifoAwP1-1:0]  occ_q;

	logic                 accept;
	logic                 note_on_w;
	logic [2:0][7:0]      cand_w;
	logic [2:0][3:0]      oct_w, pc_w;
	logic [3:0]           eff_cnt;
	logic [3:0]           lim;
	logic [msnt_pkg::TableEntries-1:0][3:0] deg;
	msnt_pkg::node_t [2:0][msnt_pkg::TableEntries-1:0] leaf;
	msnt_pkg::node_t [2:0][5:0] lvl1;
	msnt_pkg::node_t [2:0][2:0] lvl2;
	msnt_pkg::node_t      best;
	logic [2:0][6:0]      snapped;
	logic                 third_ok, fifth_ok;
	msnt_pkg::job_t       job;

	assign accept = start && !busy;
	assign busy   = (occ_q == FifoAwP1'(msnt_pkg::FifoDepth));

	// items in flight or queued, so the queue never overflows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	assign eff_cnt = (cfg.interval_count > 4'(msnt_pkg::MaxIntervals)) ?
		4'(msnt_pkg::MaxIntervals) : cfg.interval_count;
	assign lim = (eff_cnt < 4'(msnt_pkg::ArpMaxNotes)) ? eff_cnt : 4'(msnt_pkg::ArpMaxNotes);

	always_comb begin
		for (int i = 0; i < msnt_pkg::TableEntries; i++) begin
			deg[i] = msnt_pkg::deg_of(cfg.root_pitch, cfg.interval_table[4*i +: 4]);
		end
	end

	// stage 1: note, third and fifth candidates split into octave and pitch class
	always_comb begin
		note_on_w = (item_s1.status_byte[7:4] == msnt_pkg::NoteOnNibble) &&
			(item_s1.data_two != 7'd0);
		cand_w[0] = 8'(item_s1.data_one);
		cand_w[1] = 8'(item_s1.data_one) + 8'd4;
		cand_w[2] = 8'(item_s1.data_one) + 8'd7;
		for (int k = 0; k < 3; k++) begin
			oct_w[k] = msnt_pkg::div12(cand_w[k]);
			pc_w[k]  = 4'(cand_w[k] - msnt_pkg::times12(oct_w[k]));
		end
	end

	// stage 2: distances to every degree, tree reduced to three groups
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < msnt_pkg::TableEntries; i++) begin
				leaf[k][i].deg = deg[i];
				if (4'(i) < eff_cnt)
					leaf[k][i].gap = (pc_s2[k] > deg[i]) ? pc_s2[k] - deg[i] : deg[i] - pc_s2[k];
				else
					leaf[k][i].gap = 4'd12;
			end
			for (int j = 0; j < 6; j++) begin
				lvl1[k][j] = msnt_pkg::pick(leaf[k][2*j], leaf[k][2*j+1]);
			end
			for (int j = 0; j < 3; j++) begin
				lvl2[k][j] = msnt_pkg::pick(lvl1[k][2*j], lvl1[k][2*j+1]);
			end
		end
	end

	// stage 3: final pick, saturation and job assembly
	always_comb begin
		best = '0;
		for (int k = 0; k < 3; k++) begin
			best = msnt_pkg::pick(msnt_pkg::pick(grp_s3[k][0], grp_s3[k][1]), grp_s3[k][2]);
			if (eff_cnt == 4'd0)
				snapped[k] = msnt_pkg::sat7(cand_s3[k]);
			else
				snapped[k] = msnt_pkg::sat7(msnt_pkg::times12(oct_s3[k]) + 8'(best.deg));
		end
		third_ok = snapped[1] != item_s3.data_one;
		fifth_ok = (snapped[2] != item_s3.data_one) && (snapped[2] != snapped[1]);

		job            = '0;
		job.status     = item_s3.status_byte;
		job.data_two   = item_s3.data_two;
		job.sample_pos = item_s3.sample_pos;
		job.count      = CntW'(1);
		for (int i = 0; i < msnt_pkg::MaxResults; i++) begin
			job.notes[i] = item_s3.data_one;
		end
		if (note_on_s3) begin
			case (cfg.mode)
				msnt_pkg::ModeConstrain: begin
					job.notes[0] = snapped[0];
				end
				msnt_pkg::ModeHarmonize: begin
					if (eff_cnt >= 4'd3) begin
						job.notes[1] = third_ok ? snapped[1] : snapped[2];
						job.notes[2] = snapped[2];
						job.count    = CntW'(1) + CntW'(third_ok) + CntW'(fifth_ok);
					end
				end
				msnt_pkg::ModeArpeggiate: begin
					if (eff_cnt != 4'd0) begin
						job.arp   = 1'b1;
						job.count = CntW'(lim);
						for (int i = 0; i < msnt_pkg::MaxResults; i++) begin
							job.notes[i] = msnt_pkg::sat7(msnt_pkg::times12(oct_s3[0]) +
								8'(deg[i]));
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign push     = vld_s3;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
		item_s2    <= item_s1;
		note_on_s2 <= note_on_w;
		cand_s2    <= cand_w;
		oct_s2     <= oct_w;
		pc_s2      <= pc_w;
		item_s3    <= item_s2;
		note_on_s3 <= note_on_s2;
		cand_s3    <= cand_s2;
		oct_s3     <= oct_s2;
		grp_s3     <= lvl2;
	end

endmodule
`default_nettype wire

// ----- hdl/msnt_fifo.sv -----
// job queue between the front end and the emitter, register file with counters
// depends on msnt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module msnt_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire msnt_pkg::job_t push_job,
	input  wire logic           pop,
	output logic                empty,
	output msnt_pkg::job_t      head
);

	localparam int Aw = msnt_pkg::FifoAw;

	msnt_pkg::job_t       mem_q [msnt_pkg::FifoDepth];
	logic [Aw-1:0]        wr_ptr_q, rd_ptr_q;
	logic [Aw:0]          cnt_q;

	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	`MSNT_NEVER(a_no_overflow, clk, arst_n, push && !pop && (cnt_q == (Aw+1)'(msnt_pkg::FifoDepth)))
	`MSNT_NEVER(a_no_underflow, clk, arst_n, pop && empty)
	`MSNT_ASSERT(a_cnt_track, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule
`default_nettype wire

// ----- hdl/msnt_back.sv -----
// emitter: walks the note slots of the head job, one registered result a cycle
// while the queue is not empty; depends on msnt_pkg
`default_nettype none
module msnt_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           empty,
	input  wire msnt_pkg::job_t head,
	output logic                pop,
	output logic                strobe,
	output msnt_pkg::out_t      result
);

	localparam int IdxW = msnt_pkg::IdxW;
	localparam int CntW = msnt_pkg::CntW;

	logic [IdxW-1:0]  idx_q;
	logic [16:0]      pos_acc_q;
	logic             strobe_q;
	msnt_pkg::out_t   out_q;

	logic             active;
	logic             last_w;
	logic [16:0]      cur_pos;

	assign active  = !empty;
	assign cur_pos = (idx_q == '0) ? 17'(head.sample_pos) : pos_acc_q;
	assign last_w  = (CntW'(idx_q) + CntW'(1)) == head.count;
	assign pop     = active && last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active;
			if (active)
				idx_q <= last_w ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			out_q.out_status     <= head.status;
			out_q.out_data_one   <= head.notes[idx_q];
			out_q.out_data_two   <= head.data_two;
			out_q.out_sample_pos <= cur_pos;
			out_q.last           <= last_w;
			// arpeggio steps walk forward in sample time
			pos_acc_q <= head.arp ? cur_pos + 17'(msnt_pkg::ArpStepSamples) : cur_pos;
		end
	end

	assign strobe = strobe_q;
	assign result = out_q;

endmodule
`default_nettype wire

// ----- hdl/midi_scale_note_transformer_top.sv -----
// midi scale note transformer: the first result strobe of a word follows the front stage
// registers, the job queue and the output register; later results of the same word follow on
// successive cycles. a word is taken every cycle while fewer than 8 words are in flight or
// queued; the single result port sets the sustained rate, 1 to 4 results per word. async
// reset clears the config registers (pass mode) and drops all pending work; results cannot
// be held off by the receiver. depends on msnt_pkg and the front, queue and emitter
`default_nettype none
module midi_scale_note_transformer_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire msnt_pkg::in_t               item,
	output logic                             strobe,
	output msnt_pkg::out_t                   result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [msnt_pkg::PaddrW-1:0] paddr,
	input  wire logic [63:0]                 pwdata,
	output logic [63:0]                      prdata,
	output logic                             pready
);

	msnt_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	logic           push, pop, empty;
	msnt_pkg::job_t push_job, head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				msnt_pkg::RegMode:          cfg_q.mode <= msnt_pkg::mode_t'(pwdata[1:0]);
				msnt_pkg::RegRootPitch:     cfg_q.root_pitch <= pwdata[3:0];
				msnt_pkg::RegIntervalCount: cfg_q.interval_count <= pwdata[3:0];
				msnt_pkg::RegIntervalTable: cfg_q.interval_table <= pwdata[47:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			msnt_pkg::RegMode:          prdata = 64'(cfg_q.mode);
			msnt_pkg::RegRootPitch:     prdata = 64'(cfg_q.root_pitch);
			msnt_pkg::RegIntervalCount: prdata = 64'(cfg_q.interval_count);
			msnt_pkg::RegIntervalTable: prdata = 64'(cfg_q.interval_table);
			default:                    prdata = '0;
		endcase
	end

	msnt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.cfg      (cfg_q),
		.pop      (pop),
		.busy     (busy),
		.push     (push),
		.push_job (push_job)
	);

	msnt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	msnt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule
`default_nettype wire
